FILE: design/sfmi_pkg.sv
// ----------------------------------------------------------------------------
// sfmi_pkg
// Shared types and constants for the symmetric field map interpolator.
// ----------------------------------------------------------------------------
package sfmi_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_BITS  = 32;
  localparam int unsigned DIV_BITS  = POS_BITS + FRAC_BITS;
  localparam int unsigned ACC_BITS  = 52;
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [2:0] {
    CFG_GRID_X  = 3'd0,
    CFG_GRID_Y  = 3'd1,
    CFG_GRID_Z  = 3'd2,
    CFG_SPACE_X = 3'd3,
    CFG_SPACE_Y = 3'd4,
    CFG_SPACE_Z = 3'd5,
    CFG_FLIP_X  = 3'd6
  } cfg_index_e;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } component_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_CHECK,
    ST_BASE,
    ST_C_ADDR,
    ST_C_READ,
    ST_C_MAC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       write;
    logic       prep;
    logic       div_load;
    logic       div_step;
    logic       check;
    logic       base;
    logic       c_addr;
    logic       c_read;
    logic       c_mac;
    logic       finish;
    logic [2:0] corner;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_map;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/sfmi_div.sv
// ----------------------------------------------------------------------------
// sfmi_div
// Restoring divider, one quotient bit per step: {dividend, 16'b0} / divisor.
// ----------------------------------------------------------------------------
module sfmi_div (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic                            step_i,
  input  logic [sfmi_pkg::POS_BITS-1:0]   dividend_i,
  input  logic [19:0]                     divisor_i,
  output logic [sfmi_pkg::DIV_BITS-1:0]   quot_o
);
  import sfmi_pkg::*;

  logic [DIV_BITS-1:0] quot_q;
  logic [19:0]         rem_q;
  logic [20:0]         trial;
  logic                fits;

  assign trial = {rem_q, quot_q[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quot_q <= {dividend_i, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
    end else if (step_i) begin
      quot_q <= {quot_q[DIV_BITS-2:0], fits};
      rem_q  <= fits ? 20'(trial - {1'b0, divisor_i}) : trial[19:0];
    end
  end

  assign quot_o = quot_q;

endmodule

FILE: design/sfmi_ctrl.sv
// ----------------------------------------------------------------------------
// sfmi_ctrl
// Sequencer: query preparation, division steps, eight corner reads, finish.
// ----------------------------------------------------------------------------
module sfmi_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   req_type_i,
  output logic                   in_stall_o,
  input  sfmi_pkg::dp_status_t   status_i,
  output sfmi_pkg::ctrl_cmd_t    cmd_o
);
  import sfmi_pkg::*;

  state_e     state_q, state_d;
  logic [5:0] div_cnt_q, div_cnt_d;
  logic [2:0] corner_q, corner_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    corner_d  = corner_q;
    case (state_q)
      ST_IDLE:   if (accept && req_type_i) state_d = ST_PREP;
      ST_PREP:   state_d = ST_LOAD;
      ST_LOAD: begin
        state_d   = ST_DIV;
        div_cnt_d = '0;
      end
      ST_DIV: begin
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_cnt_q == 6'(DIV_BITS - 1)) state_d = ST_CHECK;
      end
      ST_CHECK:  state_d = status_i.in_map ? ST_BASE : ST_FINISH;
      ST_BASE: begin
        state_d  = ST_C_ADDR;
        corner_d = '0;
      end
      ST_C_ADDR: state_d = ST_C_READ;
      ST_C_READ: state_d = ST_C_MAC;
      ST_C_MAC: begin
        corner_d = corner_q + 3'd1;
        state_d  = (corner_q == 3'd7) ? ST_FINISH : ST_C_ADDR;
      end
      ST_FINISH: if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.corner   = corner_q;
    cmd_o.capture  = accept && req_type_i;
    cmd_o.write    = accept && !req_type_i;
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.div_load = (state_q == ST_LOAD);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.check    = (state_q == ST_CHECK);
    cmd_o.base     = (state_q == ST_BASE);
    cmd_o.c_addr   = (state_q == ST_C_ADDR);
    cmd_o.c_read   = (state_q == ST_C_READ);
    cmd_o.c_mac    = (state_q == ST_C_MAC);
    cmd_o.finish   = (state_q == ST_FINISH) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
      corner_q  <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      corner_q  <= corner_d;
    end
  end

endmodule

FILE: design/sfmi_datapath.sv
// ----------------------------------------------------------------------------
// sfmi_datapath
// Config registers, field tables, axis split, corner weights, accumulation.
// ----------------------------------------------------------------------------
module sfmi_datapath #(
  parameter int unsigned TABLE_DEPTH = 32768
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [19:0]          cfg_data_i,
  input  logic [1:0]           component_i,
  input  logic [14:0]          entry_index_i,
  input  logic signed [31:0]   entry_value_i,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  input  sfmi_pkg::ctrl_cmd_t  cmd_i,
  output sfmi_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 in_map_o,
  output logic signed [31:0]   field_x_o,
  output logic signed [31:0]   field_y_o,
  output logic signed [31:0]   field_z_o
);
  import sfmi_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // config
  logic [10:0] gx_q, gy_q, gz_q;
  logic [19:0] sx_q, sy_q, sz_q;
  logic        flip_q;
  logic [21:0] nyz_q;
  logic [32:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q   <= 11'd2;
      gy_q   <= 11'd2;
      gz_q   <= 11'd2;
      sx_q   <= 20'd1000;
      sy_q   <= 20'd1000;
      sz_q   <= 20'd1000;
      flip_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_X:  gx_q   <= cfg_data_i[10:0];
        CFG_GRID_Y:  gy_q   <= cfg_data_i[10:0];
        CFG_GRID_Z:  gz_q   <= cfg_data_i[10:0];
        CFG_SPACE_X: sx_q   <= cfg_data_i;
        CFG_SPACE_Y: sy_q   <= cfg_data_i;
        CFG_SPACE_Z: sz_q   <= cfg_data_i;
        CFG_FLIP_X:  flip_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // grid sizes are registered from the config: nyz_q first, then total_q from it
  always_ff @(posedge clk_i) begin
    nyz_q   <= 22'(gy_q) * 22'(gz_q);
    total_q <= 33'(nyz_q) * 33'(gx_q);
  end

  // tables
  logic [31:0] mem_x [TABLE_DEPTH];
  logic [31:0] mem_y [TABLE_DEPTH];
  logic [31:0] mem_z [TABLE_DEPTH];
  logic [20:0] widx;
  logic        wok;
  logic [AW-1:0] waddr, raddr_q;
  logic signed [31:0] rdx_q, rdy_q, rdz_q;

  assign widx  = 21'(entry_index_i);
  assign wok   = cmd_i.write && (widx < 21'(TABLE_DEPTH));
  assign waddr = AW'(widx);

  always_ff @(posedge clk_i) begin
    if (wok && component_i == COMP_X) mem_x[waddr] <= entry_value_i;
    if (cmd_i.c_read) rdx_q <= mem_x[raddr_q];
  end
  always_ff @(posedge clk_i) begin
    if (wok && component_i == COMP_Y) mem_y[waddr] <= entry_value_i;
    if (cmd_i.c_read) rdy_q <= mem_y[raddr_q];
  end
  always_ff @(posedge clk_i) begin
    if (wok && component_i == COMP_Z) mem_z[waddr] <= entry_value_i;
    if (cmd_i.c_read) rdz_q <= mem_z[raddr_q];
  end

  // position capture and folding
  logic signed [32:0] xx_q, yy_q, zz_q, px, py;
  logic [31:0] u_q, v_q, w_q;
  logic        uneg_q, yneg_q, zneg_q;
  logic [9:0]  half;
  logic [29:0] offs;
  logic signed [33:0] u_full;
  logic [32:0] vabs, wabs;

  assign px     = 33'(pos_x_i);
  assign py     = 33'(pos_y_i);
  assign half   = 10'((gx_q - 11'd1) >> 1);
  assign offs   = 30'(half) * 30'(sx_q);
  assign u_full = 34'(xx_q) + $signed({4'b0, offs});
  assign vabs   = yy_q[32] ? 33'(-yy_q) : 33'(yy_q);
  assign wabs   = zz_q[32] ? 33'(-zz_q) : 33'(zz_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      xx_q <= flip_q ? -px : px;
      yy_q <= flip_q ? -py : py;
      zz_q <= 33'(pos_z_i);
    end
    if (cmd_i.prep) begin
      u_q    <= u_full[31:0];
      uneg_q <= u_full[33];
      v_q    <= vabs[31:0];
      w_q    <= wabs[31:0];
      yneg_q <= yy_q[32];
      zneg_q <= zz_q[32];
    end
  end

  // axis division: cell in the upper bits, Q0.16 fraction in the lower
  logic [DIV_BITS-1:0] qx, qy, qz;

  sfmi_div u_div_x (.clk_i, .load_i(cmd_i.div_load), .step_i(cmd_i.div_step),
                    .dividend_i(u_q), .divisor_i(sx_q), .quot_o(qx));
  sfmi_div u_div_y (.clk_i, .load_i(cmd_i.div_load), .step_i(cmd_i.div_step),
                    .dividend_i(v_q), .divisor_i(sy_q), .quot_o(qy));
  sfmi_div u_div_z (.clk_i, .load_i(cmd_i.div_load), .step_i(cmd_i.div_step),
                    .dividend_i(w_q), .divisor_i(sz_q), .quot_o(qz));

  logic [31:0] ci, cj, ck;
  logic        degen, in_grid;
  logic        in_map_q;
  logic [21:0] row_q;
  logic [AW-1:0] base_q;
  logic [16:0] fu, fv, fw, gu, gv, gw;

  assign ci = qx[DIV_BITS-1:FRAC_BITS];
  assign cj = qy[DIV_BITS-1:FRAC_BITS];
  assign ck = qz[DIV_BITS-1:FRAC_BITS];
  assign fu = {1'b0, qx[FRAC_BITS-1:0]};
  assign fv = {1'b0, qy[FRAC_BITS-1:0]};
  assign fw = {1'b0, qz[FRAC_BITS-1:0]};
  assign gu = WEIGHT_ONE - fu;
  assign gv = WEIGHT_ONE - fv;
  assign gw = WEIGHT_ONE - fw;

  assign degen = (gx_q < 11'd2) || (gy_q < 11'd2) || (gz_q < 11'd2) ||
                 (sx_q == '0) || (sy_q == '0) || (sz_q == '0) ||
                 (total_q > 33'(TABLE_DEPTH));
  assign in_grid = !degen && !uneg_q &&
                   (ci < 32'(gx_q - 11'd1)) && (cj < 32'(gy_q - 11'd1)) &&
                   (ck < 32'(gz_q - 11'd1));

  // corner address and weight
  logic [32:0] caddr;
  logic [16:0] wa, wb, wc, wab_q, wt_q;
  logic [33:0] pab, pabc;

  assign caddr = 33'(base_q) + (cmd_i.corner[2] ? 33'(nyz_q) : 33'd0)
               + (cmd_i.corner[1] ? 33'(gz_q) : 33'd0) + 33'(cmd_i.corner[0]);
  assign wa   = cmd_i.corner[2] ? fu : gu;
  assign wb   = cmd_i.corner[1] ? fv : gv;
  assign wc   = cmd_i.corner[0] ? fw : gw;
  assign pab  = 34'(wa) * 34'(wb);
  assign pabc = 34'(wab_q) * 34'(wc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_map_q <= 1'b0;
    end else if (cmd_i.check) begin
      in_map_q <= in_grid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) row_q  <= 22'(ci[9:0]) * 22'(gy_q) + 22'(cj[9:0]);
    if (cmd_i.base)  base_q <= AW'(33'(row_q) * 33'(gz_q) + 33'(ck[9:0]));
    if (cmd_i.c_addr) begin
      raddr_q <= AW'(caddr);
      wab_q   <= pab[32:16];
    end
    if (cmd_i.c_read) wt_q <= pabc[32:16];
  end

  // accumulation
  logic signed [ACC_BITS-1:0] accx_q, accy_q, accz_q;
  logic signed [17:0]         wts;
  logic signed [49:0]         prod_x, prod_y, prod_z;

  assign wts    = $signed({1'b0, wt_q});
  assign prod_x = wts * rdx_q;
  assign prod_y = wts * rdy_q;
  assign prod_z = wts * rdz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      accx_q <= '0;
      accy_q <= '0;
      accz_q <= '0;
    end else if (cmd_i.c_mac) begin
      accx_q <= accx_q + ACC_BITS'(prod_x);
      accy_q <= accy_q + ACC_BITS'(prod_y);
      accz_q <= accz_q + ACC_BITS'(prod_z);
    end
  end

  // scale toward zero, restore sign, saturate
  function automatic logic [31:0] finish_field(input logic signed [ACC_BITS-1:0] acc,
                                               input logic neg);
    logic signed [ACC_BITS-1:0] adj;
    logic signed [36:0]         r;
    adj = acc[ACC_BITS-1] ? (acc + ACC_BITS'(65535)) : acc;
    r   = 37'(adj >>> FRAC_BITS);
    if (neg) r = -r;
    if (r > 37'sd2147483647) return 32'h7FFF_FFFF;
    if (r < -37'sd2147483648) return 32'h8000_0000;
    return r[31:0];
  endfunction

  logic out_valid_q, in_map_oq;
  logic [31:0] fx_q, fy_q, fz_q;

  assign status_o.in_map   = in_grid;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      in_map_oq <= in_map_q;
      fx_q <= in_map_q ? finish_field(accx_q, yneg_q ^ flip_q) : 32'd0;
      fy_q <= in_map_q ? finish_field(accy_q, flip_q) : 32'd0;
      fz_q <= in_map_q ? finish_field(accz_q, yneg_q ^ zneg_q) : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_map_o    = in_map_oq;
  assign field_x_o   = fx_q;
  assign field_y_o   = fy_q;
  assign field_z_o   = fz_q;

endmodule

FILE: design/symmetric_field_map_interpolator_core.sv
// ----------------------------------------------------------------------------
// symmetric_field_map_interpolator_core
// Trilinear field map lookup over the y >= 0, z >= 0 quadrant with mirror folding.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) carries one word: a table load
//   (req_type 0) or a position query (req_type 1)
//   a load writes one word of the x, y or z table and keeps the input free;
//   it gives no output word
//   a query gives exactly one output word (out_valid_o / out_stall_i)
//   a query runs a prep and a load step, one step per quotient bit of
//   the three radix-2 dividers running side by side, the check and
//   base index steps, then for each of eight corners an address step,
//   a registered table read and a multiply-accumulate, then the output
//   register; queries out of grid skip the corner walk
//   one query is in flight at a time; the next word is taken as soon as
//   the result sits in the output register, even while it is stalled
//   a stalled output holds its word; a finished query then waits until
//   the output register frees up
//   reset clears control and sets the grid config to 2 points and 1000 um
//   spacing; table contents are undefined until loaded
//   config writes (cfg_we_i) are meant only while the block is idle
// ----------------------------------------------------------------------------
module symmetric_field_map_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [1:0]         component_i,
  input  logic [14:0]        entry_index_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  // output words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               in_map_o,
  output logic signed [31:0] field_x_o,
  output logic signed [31:0] field_y_o,
  output logic signed [31:0] field_z_o
);
  import sfmi_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: one query at a time
  sfmi_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .req_type_i,
    .in_stall_o,
    .status_i (status),
    .cmd_o    (cmd)
  );

  // tables, dividers, weights and output register
  sfmi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .component_i,
    .entry_index_i,
    .entry_value_i,
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o,
    .out_stall_i,
    .in_map_o,
    .field_x_o,
    .field_y_o,
    .field_z_o
  );

endmodule

FILE: design/sfmi_checker.sv
// ----------------------------------------------------------------------------
// sfmi_checker
// Port-level checks for the interpolator core, attached by bind.
// ----------------------------------------------------------------------------
module sfmi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               req_type_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               in_map_o,
  input logic signed [31:0] field_x_o,
  input logic signed [31:0] field_y_o,
  input logic signed [31:0] field_z_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(field_x_o) &&
    $stable(field_y_o) && $stable(field_z_o) && $stable(in_map_o))
    else $error("stalled output word changed");

  // out of grid gives zero fields
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_map_o |-> field_x_o == 0 && field_y_o == 0 && field_z_o == 0)
    else $error("out of grid word with nonzero field");

  // a query keeps the input busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i |=> in_stall_o)
    else $error("input free right after a query");

  // a load leaves the input free in the next cycle
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !req_type_i |=> !in_stall_o)
    else $error("input busy after a load");

endmodule

bind symmetric_field_map_interpolator_core sfmi_checker u_sfmi_checker (.*);

FILE: dv/sfmi_field_checker.sv
// ----------------------------------------------------------------------------
// sfmi_field_checker
// Watches the word channels of the field map interpolator, keeps its own
// copy of the tables and grid setup, predicts each query answer and
// compares it, in_map flag and all fields, with what the block returns.
// ----------------------------------------------------------------------------
module sfmi_field_checker
  import sfmi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               req_type_i,
  input  logic [1:0]         component_i,
  input  logic [14:0]        entry_index_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               in_map_i,
  input  logic signed [31:0] field_x_i,
  input  logic signed [31:0] field_y_i,
  input  logic signed [31:0] field_z_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic               in_map;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
  } answer_t;

  logic signed [31:0] tab_x [TABLE_DEPTH];
  logic signed [31:0] tab_y [TABLE_DEPTH];
  logic signed [31:0] tab_z [TABLE_DEPTH];
  logic [10:0] nx, ny, nz;
  logic [19:0] sx, sy, sz;
  logic        flip;
  answer_t     answers_due [$];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic answer_t field_at(longint px, longint py, longint pz);
    answer_t a;
    longint xx, yy, u, v, w, ci, cj, ck, bx, by, bz;
    longint fr [3];
    longint wa, wb, wc, wt;
    longint unsigned base, id;
    a = '0;
    if (nx < 2 || ny < 2 || nz < 2 || sx == 0 || sy == 0 || sz == 0 ||
        longint'(nx) * ny * nz > TABLE_DEPTH) return a;
    xx = flip ? -px : px;
    yy = flip ? -py : py;
    u  = xx + ((longint'(nx) - 1) / 2) * sx;
    v  = yy < 0 ? -yy : yy;
    w  = pz < 0 ? -pz : pz;
    if (u < 0) return a;
    ci = u / sx; cj = v / sy; ck = w / sz;
    fr[0] = ((u % sx) << 16) / sx;
    fr[1] = ((v % sy) << 16) / sy;
    fr[2] = ((w % sz) << 16) / sz;
    if (ci >= nx - 1 || cj >= ny - 1 || ck >= nz - 1) return a;
    base = (ci * ny + cj) * nz + ck;
    bx = 0; by = 0; bz = 0;
    for (int n = 0; n < 8; n++) begin
      wa = n[2] ? fr[0] : 65536 - fr[0];
      wb = n[1] ? fr[1] : 65536 - fr[1];
      wc = n[0] ? fr[2] : 65536 - fr[2];
      wt = (((wa * wb) >> 16) * wc) >> 16;
      id = base + n[2] * longint'(ny) * nz + n[1] * longint'(nz) + n[0];
      bx += wt * tab_x[id];
      by += wt * tab_y[id];
      bz += wt * tab_z[id];
    end
    // division truncates toward zero, as the block does
    bx /= 65536; by /= 65536; bz /= 65536;
    if (yy < 0) begin
      bx = -bx; bz = -bz;
    end
    if (pz < 0) bz = -bz;
    if (flip) begin
      bx = -bx; by = -by;
    end
    a.in_map = 1'b1;
    a.fx = clamp32(bx); a.fy = clamp32(by); a.fz = clamp32(bz);
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      nx <= 11'd2; ny <= 11'd2; nz <= 11'd2;
      sx <= 20'd1000; sy <= 20'd1000; sz <= 20'd1000;
      flip <= 1'b0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_GRID_X:  nx <= cfg_data_i[10:0];
          CFG_GRID_Y:  ny <= cfg_data_i[10:0];
          CFG_GRID_Z:  nz <= cfg_data_i[10:0];
          CFG_SPACE_X: sx <= cfg_data_i;
          CFG_SPACE_Y: sy <= cfg_data_i;
          CFG_SPACE_Z: sz <= cfg_data_i;
          CFG_FLIP_X:  flip <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i) begin
          answers_due.push_back(field_at(pos_x_i, pos_y_i, pos_z_i));
        end else if (entry_index_i < TABLE_DEPTH) begin
          case (component_i)
            COMP_X: tab_x[entry_index_i] = entry_value_i;
            COMP_Y: tab_y[entry_index_i] = entry_value_i;
            COMP_Z: tab_z[entry_index_i] = entry_value_i;
            default: ;
          endcase
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got = {in_map_i, field_x_i, field_y_i, field_z_i};
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected word in_map=%0b x=%0d y=%0d z=%0d", $time,
                   got.in_map, got.fx, got.fy, got.fz);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            $display("%0t: expected in_map=%0b x=%0d y=%0d z=%0d", $time,
                     want.in_map, want.fx, want.fy, want.fz);
            $display("%0t:   actual in_map=%0b x=%0d y=%0d z=%0d", $time,
                     got.in_map, got.fx, got.fy, got.fz);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= answers_due.size();
    end
  end

endmodule

FILE: dv/symmetric_field_map_interpolator_core_test.sv
// ----------------------------------------------------------------------------
// symmetric_field_map_interpolator_core_test
// Drives table loads, position queries and grid setups into the core with
// random gaps and output stalls; a checker beside the core predicts and
// compares every answer.
// ----------------------------------------------------------------------------
module symmetric_field_map_interpolator_core_test;
  import sfmi_pkg::*;

  localparam int unsigned DEPTH = 32768;
  localparam longint CYCLE_LIMIT = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [19:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [1:0]         component_i = '0;
  logic [14:0]        entry_index_i = '0;
  logic signed [31:0] entry_value_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               in_map_o;
  logic signed [31:0] field_x_o, field_y_o, field_z_o;
  int                 fail_count, pending;
  longint             cycles = 0;
  // long receiver hold-off requested by the stimulus
  bit                 hold_off = 1'b0;
  // grid shape as last written, used to aim queries at the loaded region
  int                 gx, gy, gz, dx, dy, dz;
  bit                 gflip;

  always #1 clk_i = ~clk_i;

  symmetric_field_map_interpolator_core #(.TABLE_DEPTH(DEPTH)) dut (.*);

  sfmi_field_checker #(.TABLE_DEPTH(DEPTH)) checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .component_i,
    .entry_index_i, .entry_value_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .out_valid_i(out_valid_o), .out_stall_i, .in_map_i(in_map_o),
    .field_x_i(field_x_o), .field_y_i(field_y_o), .field_z_i(field_z_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall per word, or one long hold when asked
  initial begin
    int waitc;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      waitc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (waitc > 0) begin
        out_stall_i <= 1'b1;
        repeat (waitc - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      // hold low until one word goes out
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // one word on the input channel, with a random gap first
  task automatic send_word(bit rq, logic [1:0] comp, logic [14:0] idx,
                           logic [31:0] val, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    req_type_i    <= rq;
    component_i   <= comp;
    entry_index_i <= idx;
    entry_value_i <= val;
    pos_x_i       <= px;
    pos_y_i       <= py;
    pos_z_i       <= pz;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic load_word(logic [1:0] comp, int idx, logic [31:0] val);
    send_word(1'b0, comp, idx[14:0], val, $urandom, $urandom, $urandom);
  endtask

  task automatic query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_word(1'b1, $urandom, $urandom, $urandom, px, py, pz);
  endtask

  // wait for the block to drain before touching the registers
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, int value);
    cfg_we_i     = 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[19:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // new grid setup, then fill every table word it can reach
  task automatic set_grid(int cx, int cy, int cz, int spx, int spy, int spz, bit fl);
    settle();
    write_reg(CFG_GRID_X, cx);  write_reg(CFG_GRID_Y, cy);
    write_reg(CFG_GRID_Z, cz);  write_reg(CFG_SPACE_X, spx);
    write_reg(CFG_SPACE_Y, spy); write_reg(CFG_SPACE_Z, spz);
    write_reg(CFG_FLIP_X, fl);
    gx = cx; gy = cy; gz = cz; dx = spx; dy = spy; dz = spz; gflip = fl;
    if (cx >= 2 && cy >= 2 && cz >= 2 && cx * cy * cz <= DEPTH)
      for (int e = 0; e < cx * cy * cz; e++)
        for (int c = 0; c < 3; c++)
          load_word(c, e, rand_value());
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // a position mostly inside the grid, sometimes just outside or anywhere
  function automatic logic [31:0] rand_pos(int n, int sp, bit is_x);
    longint span, p;
    span = longint'(n - 1) * sp;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: p = span + $urandom_range(0, 3);
      default: p = $urandom_range(0, span - 1);
    endcase
    if (is_x) p = p - ((n - 1) / 2) * longint'(sp);
    else if ($urandom_range(0, 1)) p = -p;
    if (is_x && $urandom_range(0, 1) && p >= 0) p = -p;
    return p[31:0];
  endfunction

  task automatic rand_query();
    query(rand_pos(gx, dx, 1), rand_pos(gy, dy, 0), rand_pos(gz, dz, 0));
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset grid is 2x2x2 with 1000 um spacing
    gx = 2; gy = 2; gz = 2; dx = 1000; dy = 1000; dz = 1000; gflip = 0;
    for (int e = 0; e < 8; e++)
      for (int c = 0; c < 3; c++)
        load_word(c, e, (e == 0) ? 32'h80000000 : (e == 7) ? 32'h7fffffff : $urandom);
    // bad loads: component 3 and the highest index (kept in range but unused)
    send_word(1'b0, 2'd3, 15'h7fff, 32'hffffffff, '0, '0, '0);
    load_word(COMP_X, 32767, 32'h12345678);
    query(32'd0, 32'd0, 32'd0);             // corner, full weight on the minimum entry
    query(-32'sd1, 32'd0, 32'd0);           // just below origin
    query(32'd999, -32'sd999, -32'sd999);   // deep fractions, sign restore
    query(32'd1000, 32'd0, 32'd0);          // upper x edge
    query(32'd0, 32'd1000, 32'd0);
    query(32'd0, 32'd0, 32'd1000);
    query(32'h7fffffff, 32'h80000000, 32'h80000000);
    query(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    query(32'd500, -32'sd500, 32'd500);

    // flip and degenerate setups
    settle();
    write_reg(CFG_FLIP_X, 1);
    gflip = 1;
    query(32'd0, 32'd0, 32'd0);
    query(-32'sd999, -32'sd1, 32'd3);
    query(32'd1, 32'd1, 32'd1);
    settle();
    write_reg(CFG_FLIP_X, 0);
    write_reg(CFG_GRID_X, 1);
    query(32'd0, 32'd0, 32'd0);
    settle();
    write_reg(CFG_GRID_X, 2);
    write_reg(CFG_SPACE_Y, 0);
    query(32'd0, 32'd0, 32'd0);
    settle();
    // grid too large for the tables
    write_reg(CFG_SPACE_Y, 1000);
    write_reg(CFG_GRID_X, 1024);
    write_reg(CFG_GRID_Y, 1024);
    query(32'd0, 32'd0, 32'd0);

    // random phases over several setups, extremes included
    set_grid(3, 3, 3, 1, 1, 1, 0);
    repeat (25) rand_query();
    set_grid(3, 2, 2, 1000000, 777, 65536, 1);
    repeat (25) rand_query();
    // hold the output for a long stretch while words keep coming
    hold_off = 1'b1;
    repeat (10) send_word(1'b1, 0, 0, 0, rand_pos(gx, dx, 1),
                          rand_pos(gy, dy, 0), rand_pos(gz, dz, 0), 1);
    set_grid(3, 2, 2, 3, 1000000, 12345, 0);
    repeat (25) rand_query();
    set_grid(2, 3, 2, 999999, 1, 1000, 1);
    repeat (25) rand_query();
    set_grid(2, 2, 3, 50, 50, 1, 0);
    repeat (25) rand_query();
    set_grid(2, 2, 2, 1000, 1000, 1000, 0);
    repeat (40) begin
      if ($urandom_range(0, 5) == 0)
        send_word(1'b0, 2'd3, $urandom, $urandom, '0, '0, '0);
      else if ($urandom_range(0, 5) == 0)
        load_word($urandom_range(0, 2), $urandom_range(0, 63), rand_value());
      else
        rand_query();
    end
    // degenerate grid too large for the tables
    settle();
    write_reg(CFG_GRID_X, 2047);
    write_reg(CFG_GRID_Y, 2047);
    repeat (5) rand_query();

    // drain
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
design/sfmi_pkg.sv
design/sfmi_div.sv
design/sfmi_ctrl.sv
design/sfmi_datapath.sv
design/symmetric_field_map_interpolator_core.sv
design/sfmi_checker.sv
dv/sfmi_field_checker.sv
dv/symmetric_field_map_interpolator_core_test.sv
